// ===== src/rag_deadlock_detector_unit_defines.svh =====
// ----------------------------------------------------------------------------
// RAG deadlock detector assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef RAG_DEADLOCK_DETECTOR_UNIT_DEFINES_SVH
`define RAG_DEADLOCK_DETECTOR_UNIT_DEFINES_SVH

// same-cycle implication
`define RDD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rdd check failed");

// next-cycle implication
`define RDD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rdd check failed");

`endif

// ===== src/rdd_pkg.sv =====
// ----------------------------------------------------------------------------
// RAG deadlock detector package
// Default sizes, controller commands and datapath status.
// ----------------------------------------------------------------------------
package rdd_pkg;

    localparam int RDD_NUM_PROCS     = 32;
    localparam int RDD_NUM_RESOURCES = 32;
    localparam int RDD_MAX_EDGES     = 256;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_OD_UPD,
        CMD_CP_RD,
        CMD_CP_WR,
        CMD_POP,
        CMD_POP_LD,
        CMD_E_RD,
        CMD_E_CHK,
        CMD_W_CHK,
        CMD_SC_RD,
        CMD_SC_CHK,
        CMD_FIN
    } t_cmd;

    typedef struct packed {
        logic add;
        logic v_last;
        logic p_last;
        logic sp_zero;
        logic etot_zero;
        logic e_last;
        logic match;
        logic hit;
        logic pend;
        logic out_free;
    } t_status;

endpackage

// ===== src/rdd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rdd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/rdd_ctrl.sv =====
// ----------------------------------------------------------------------------
// RAG deadlock detector controller
// Sequences edge insert, degree copy, peel and process scan.
// ----------------------------------------------------------------------------
module rdd_ctrl import rdd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_ODU, S_CPR, S_CPW, S_POP, S_POPL, S_ERD, S_ECK, S_WCK,
        S_SCR, S_SCK, S_FIN
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = CMD_ACCEPT;
                    n_state = i_status.add ? S_ODU : S_CPR;
                end
            end
            S_ODU: begin
                o_cmd   = CMD_OD_UPD;
                n_state = S_CPR;
            end
            S_CPR: begin
                o_cmd   = CMD_CP_RD;
                n_state = S_CPW;
            end
            S_CPW: begin
                o_cmd   = CMD_CP_WR;
                n_state = i_status.v_last ? S_POP : S_CPR;
            end
            S_POP: begin
                o_cmd   = CMD_POP;
                n_state = i_status.sp_zero ? S_SCR : S_POPL;
            end
            S_POPL: begin
                o_cmd   = CMD_POP_LD;
                n_state = i_status.etot_zero ? S_POP : S_ERD;
            end
            S_ERD: begin
                o_cmd   = CMD_E_RD;
                n_state = S_ECK;
            end
            S_ECK: begin
                o_cmd = CMD_E_CHK;
                if (i_status.match) begin
                    n_state = S_WCK;
                end else begin
                    n_state = i_status.e_last ? S_POP : S_ERD;
                end
            end
            S_WCK: begin
                o_cmd   = CMD_W_CHK;
                n_state = i_status.e_last ? S_POP : S_ERD;
            end
            S_SCR: begin
                o_cmd   = CMD_SC_RD;
                n_state = S_SCK;
            end
            S_SCK: begin
                if (!(i_status.hit && i_status.pend && !i_status.out_free)) begin
                    o_cmd   = CMD_SC_CHK;
                    n_state = i_status.p_last ? S_FIN : S_SCR;
                end
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd   = CMD_FIN;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== src/rdd_dpath.sv =====
// ----------------------------------------------------------------------------
// RAG deadlock detector datapath
// Edge, degree, working degree and stack memories with counters and output beat.
// ----------------------------------------------------------------------------
module rdd_dpath import rdd_pkg::*; #(
    parameter int NUM_PROCS     = RDD_NUM_PROCS,
    parameter int NUM_RESOURCES = RDD_NUM_RESOURCES,
    parameter int MAX_EDGES     = RDD_MAX_EDGES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_status    o_status,
    input  logic [4:0] i_proc_id,
    input  logic [4:0] i_res_id,
    input  logic       i_kind,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output logic       o_deadlocked,
    output logic [4:0] o_stuck_proc,
    output logic       o_last,
    output logic       o_overflow
);

    localparam int NV  = NUM_PROCS + NUM_RESOURCES;
    localparam int VW  = $clog2(NV);
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int EIW = $clog2(MAX_EDGES);
    localparam int DW  = EW;
    localparam int SPW = $clog2(NV + 1);

    logic [EW-1:0]  r_etot;
    logic [NV-1:0]  r_odv;
    logic [VW-1:0]  r_from, r_v, r_cur, r_src, r_pend_id;
    logic [SPW-1:0] r_sp;
    logic [EIW-1:0] r_e;
    logic           r_ovf, r_pend;
    logic           r_ovld, r_dl, r_last, r_oovf;
    logic [4:0]     r_id;

    logic          w_ok, w_full, w_add;
    logic [VW-1:0] w_pv, w_rv, w_from, w_to;
    logic [2*VW-1:0] e_rd;
    logic [VW-1:0] e_from, e_to;
    logic [DW-1:0] od_rd, wk_rd, w_odval, od_wdata;
    logic [VW-1:0] st_rd;

    logic          od_re, wk_we, wk_re, st_we, st_re;
    logic [VW-1:0] od_raddr, wk_waddr, wk_raddr, st_wdata, st_waddr, st_raddr;
    logic [DW-1:0] wk_wdata;

    assign w_ok   = (7'(i_proc_id) < 7'(NUM_PROCS)) && (7'(i_res_id) < 7'(NUM_RESOURCES));
    assign w_full = (r_etot == EW'(MAX_EDGES));
    assign w_add  = w_ok && !w_full;
    assign w_pv   = VW'(i_proc_id);
    assign w_rv   = VW'(NUM_PROCS) + VW'(i_res_id);
    assign w_from = i_kind ? w_rv : w_pv;
    assign w_to   = i_kind ? w_pv : w_rv;

    assign e_from  = e_rd[2*VW-1:VW];
    assign e_to    = e_rd[VW-1:0];
    assign w_odval = r_odv[r_v] ? od_rd : '0;
    assign od_wdata = (r_odv[r_from] ? od_rd : '0) + DW'(1);

    always_comb begin
        od_re    = (i_cmd == CMD_ACCEPT) || (i_cmd == CMD_CP_RD);
        od_raddr = (i_cmd == CMD_CP_RD) ? r_v : w_from;

        wk_we    = 1'b0;
        wk_waddr = r_v;
        wk_wdata = w_odval;
        wk_re    = 1'b0;
        wk_raddr = r_v;
        st_we    = 1'b0;
        st_waddr = r_sp[VW-1:0];
        st_wdata = r_v;
        st_re    = (i_cmd == CMD_POP) && (r_sp != '0);
        st_raddr = VW'(r_sp - SPW'(1));

        case (i_cmd)
            CMD_CP_WR: begin
                wk_we = 1'b1;
                st_we = (w_odval == '0);
            end
            CMD_E_CHK: begin
                wk_re    = (e_to == r_cur);
                wk_raddr = e_from;
            end
            CMD_W_CHK: begin
                wk_we    = (wk_rd != '0);
                wk_waddr = r_src;
                wk_wdata = wk_rd - DW'(1);
                st_we    = (wk_rd == DW'(1));
                st_wdata = r_src;
            end
            CMD_SC_RD: begin
                wk_re = 1'b1;
            end
            default: begin
            end
        endcase
    end

    rdd_ram #(.WIDTH(2*VW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    ((i_cmd == CMD_ACCEPT) && w_add),
        .i_waddr (r_etot[EIW-1:0]),
        .i_wdata ({w_from, w_to}),
        .i_re    (i_cmd == CMD_E_RD),
        .i_raddr (r_e),
        .o_rdata (e_rd)
    );

    rdd_ram #(.WIDTH(DW), .DEPTH(NV)) u_od_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd == CMD_OD_UPD),
        .i_waddr (r_from),
        .i_wdata (od_wdata),
        .i_re    (od_re),
        .i_raddr (od_raddr),
        .o_rdata (od_rd)
    );

    rdd_ram #(.WIDTH(DW), .DEPTH(NV)) u_work_ram (
        .i_clk   (i_clk),
        .i_we    (wk_we),
        .i_waddr (wk_waddr),
        .i_wdata (wk_wdata),
        .i_re    (wk_re),
        .i_raddr (wk_raddr),
        .o_rdata (wk_rd)
    );

    rdd_ram #(.WIDTH(VW), .DEPTH(NV)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_etot <= '0;
            r_odv  <= '0;
            r_ovld <= 1'b0;
            r_sp   <= '0;
            r_v    <= '0;
            r_pend <= 1'b0;
        end else begin
            if (r_ovld && !i_out_stall) begin
                r_ovld <= 1'b0;
            end
            case (i_cmd)
                CMD_ACCEPT: begin
                    r_from <= w_from;
                    r_ovf  <= w_ok && w_full;
                    r_v    <= '0;
                    r_sp   <= '0;
                    r_pend <= 1'b0;
                end
                CMD_OD_UPD: begin
                    r_odv[r_from] <= 1'b1;
                    r_etot        <= r_etot + EW'(1);
                end
                CMD_CP_WR: begin
                    if (w_odval == '0) begin
                        r_sp <= r_sp + SPW'(1);
                    end
                    r_v <= (r_v == VW'(NV - 1)) ? '0 : r_v + VW'(1);
                end
                CMD_POP: begin
                    if (r_sp != '0) begin
                        r_sp <= r_sp - SPW'(1);
                    end
                end
                CMD_POP_LD: begin
                    r_cur <= st_rd;
                    r_e   <= '0;
                end
                CMD_E_CHK: begin
                    if (e_to == r_cur) begin
                        r_src <= e_from;
                    end else begin
                        r_e <= r_e + EIW'(1);
                    end
                end
                CMD_W_CHK: begin
                    if (wk_rd == DW'(1)) begin
                        r_sp <= r_sp + SPW'(1);
                    end
                    r_e <= r_e + EIW'(1);
                end
                CMD_SC_CHK: begin
                    if (wk_rd != '0) begin
                        if (r_pend) begin
                            r_ovld <= 1'b1;
                            r_dl   <= 1'b1;
                            r_id   <= 5'(r_pend_id);
                            r_last <= 1'b0;
                            r_oovf <= r_ovf;
                        end
                        r_pend    <= 1'b1;
                        r_pend_id <= r_v;
                    end
                    r_v <= r_v + VW'(1);
                end
                CMD_FIN: begin
                    r_ovld <= 1'b1;
                    r_dl   <= r_pend;
                    r_id   <= r_pend ? 5'(r_pend_id) : 5'd0;
                    r_last <= 1'b1;
                    r_oovf <= r_ovf;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_status.add       = w_add;
        o_status.v_last    = (r_v == VW'(NV - 1));
        o_status.p_last    = (r_v == VW'(NUM_PROCS - 1));
        o_status.sp_zero   = (r_sp == '0);
        o_status.etot_zero = (r_etot == '0);
        o_status.e_last    = ((EW'(r_e) + EW'(1)) == r_etot);
        o_status.match     = (e_to == r_cur);
        o_status.hit       = (wk_rd != '0);
        o_status.pend      = r_pend;
        o_status.out_free  = !r_ovld || !i_out_stall;
    end

    assign o_out_valid  = r_ovld;
    assign o_deadlocked = r_dl;
    assign o_stuck_proc = r_id;
    assign o_last       = r_last;
    assign o_overflow   = r_oovf;

endmodule

// ===== src/rag_deadlock_detector_unit.sv =====
// ----------------------------------------------------------------------------
// RAG deadlock detector
// Adds at most one graph edge per input beat, peels zero out-degree vertices and
// reports the processes that the peel leaves.
// ----------------------------------------------------------------------------
// One input beat is taken at a time; the input stalls until its last result
// beat is loaded into the output register. Each beat runs the edge store (when
// the edge is added), a degree copy over all NUM_PROCS + NUM_RESOURCES
// vertices, the peel and a scan over the NUM_PROCS processes, and is held by
// any output stall. The peel dominates: every peeled vertex walks the whole
// edge memory through its single read port. Results of one beat come out in
// ascending process id, last set on the final beat.
// ----------------------------------------------------------------------------
module rag_deadlock_detector_unit import rdd_pkg::*; #(
    parameter int NUM_PROCS     = RDD_NUM_PROCS,
    parameter int NUM_RESOURCES = RDD_NUM_RESOURCES,
    parameter int MAX_EDGES     = RDD_MAX_EDGES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [4:0] i_proc_id,
    input  logic [4:0] i_res_id,
    input  logic       i_kind,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_deadlocked,
    output logic [4:0] o_stuck_proc,
    output logic       o_last,
    output logic       o_overflow
);

    t_cmd    w_cmd;
    t_status w_status;

    rdd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    rdd_dpath #(
        .NUM_PROCS     (NUM_PROCS),
        .NUM_RESOURCES (NUM_RESOURCES),
        .MAX_EDGES     (MAX_EDGES)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_proc_id    (i_proc_id),
        .i_res_id     (i_res_id),
        .i_kind       (i_kind),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_deadlocked (o_deadlocked),
        .o_stuck_proc (o_stuck_proc),
        .o_last       (o_last),
        .o_overflow   (o_overflow)
    );

endmodule

// ===== src/rdd_checker.sv =====
// ----------------------------------------------------------------------------
// RAG deadlock detector checker
// Port-level properties of the detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "rag_deadlock_detector_unit_defines.svh"

module rdd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_deadlocked,
    input logic [4:0] o_stuck_proc,
    input logic       o_last,
    input logic       o_overflow
);

    `RDD_ASSERT_IMP(a_clear_single, o_out_valid && !o_deadlocked, o_last && (o_stuck_proc == 5'd0))
    `RDD_ASSERT_IMP(a_nonlast_dl, o_out_valid && !o_last, o_deadlocked)
    `RDD_ASSERT_NXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    `RDD_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_stuck_proc) && $stable(o_last) && $stable(o_deadlocked) && $stable(o_overflow))

endmodule

bind rag_deadlock_detector_unit rdd_checker u_rdd_checker (.*);
